// ===== src/sps_pkg.sv =====
`default_nettype none
package sps_pkg;

  // Sizes of the pattern window and the replacement string.
  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int RLEN_W  = 6;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RIDX_W  = $clog2(REPLACE_MAX);
  localparam int WIDX_W  = $clog2(PATTERN_MAX);

  // Configuration register indexes.
  localparam logic [2:0] REG_MATCH_PATTERN  = 3'd0;
  localparam logic [2:0] REG_MATCH_LENGTH   = 3'd1;
  localparam logic [2:0] REG_REPLACE_WORD0  = 3'd2;
  localparam logic [2:0] REG_REPLACE_WORD1  = 3'd3;
  localparam logic [2:0] REG_REPLACE_WORD2  = 3'd4;
  localparam logic [2:0] REG_REPLACE_WORD3  = 3'd5;
  localparam logic [2:0] REG_REPLACE_LENGTH = 3'd6;
  localparam logic [2:0] REG_ONCE_MODE      = 3'd7;

  // Configuration as seen by the front and back parts, lengths already clamped.
  typedef struct packed {
    logic [PATTERN_MAX*8-1:0] match_pattern;
    logic [PLEN_W-1:0]        match_len;
    logic [REPLACE_MAX*8-1:0] replace_bytes;
    logic [RLEN_W-1:0]        replace_len;
    logic                     once_mode;
  } cfg_t;

  // One queued request: a run of window bytes or the replacement string.
  // A count of zero is the empty end-of-stream marker.
  typedef struct packed {
    logic                     is_replace;
    logic [PATTERN_MAX*8-1:0] seq_bytes;
    logic [RLEN_W-1:0]        count;
    logic                     eos;
  } cmd_t;

  // ASCII lowercase for A to Z only.
  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sps_front.sv =====
`default_nettype none
module sps_front
  import sps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_stream,
  output logic            cmd_push,
  output cmd_t            cmd
);

  logic [7:0]        win [PATTERN_MAX];
  logic [PLEN_W-1:0] held;
  logic              replaced;

  logic [7:0]        win_next [PATTERN_MAX];
  logic [PLEN_W-1:0] held_next;
  logic              replaced_next;

  logic [7:0]        seq [PATTERN_MAX];
  logic [PLEN_W-1:0] fill;
  logic [PLEN_W-1:0] n;
  logic              is_match;
  logic              rep;
  logic [PLEN_W:0]   src;

  // Window with the new byte appended, and the compare against the pattern.
  always_comb begin
    fill     = held + PLEN_W'(1);
    is_match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (PLEN_W'(i) < held) begin
        seq[i] = win[i];
      end else if (PLEN_W'(i) == held) begin
        seq[i] = data_byte;
      end else begin
        seq[i] = 8'h00;
      end
      if (PLEN_W'(i) < cfg.match_len &&
          lower_byte(seq[i]) != cfg.match_pattern[i*8 +: 8]) begin
        is_match = 1'b0;
      end
    end
  end

  // Decide how many window bytes leave, or whether the replacement goes out.
  always_comb begin
    n   = '0;
    rep = 1'b0;
    priority if (cfg.once_mode && replaced) begin
      n = fill;
    end else if (held >= cfg.match_len) begin
      n = end_of_stream ? fill : fill - (cfg.match_len - PLEN_W'(1));
    end else if (fill == cfg.match_len) begin
      if (is_match) begin
        rep = 1'b1;
      end else begin
        n = end_of_stream ? fill : PLEN_W'(1);
      end
    end else begin
      n = end_of_stream ? fill : '0;
    end
  end

  // Request toward the queue; empty requests are dropped unless they end the stream.
  always_comb begin
    cmd.is_replace = rep && (cfg.replace_len != '0);
    cmd.seq_bytes  = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      cmd.seq_bytes[i*8 +: 8] = seq[i];
    end
    cmd.count = rep ? cfg.replace_len : RLEN_W'(n);
    cmd.eos   = end_of_stream;
    cmd_push  = accept && (cmd.count != '0 || end_of_stream);
  end

  // Next window state: drop the emitted bytes from the front.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      src = (PLEN_W+1)'(i) + {1'b0, n};
      if (end_of_stream || rep || src >= (PLEN_W+1)'(PATTERN_MAX)) begin
        win_next[i] = 8'h00;
      end else begin
        win_next[i] = seq[src[WIDX_W-1:0]];
      end
    end
    held_next     = (end_of_stream || rep) ? '0 : fill - n;
    replaced_next = end_of_stream ? 1'b0 : (rep ? 1'b1 : replaced);
  end

  // Window state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      replaced <= 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win[i] <= 8'h00;
      end
    end else if (accept) begin
      held     <= held_next;
      replaced <= replaced_next;
      win      <= win_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sps_cmd_queue.sv =====
`default_nettype none
module sps_cmd_queue
  import sps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      head,
  output logic      not_empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/sps_back.sv =====
`default_nettype none
module sps_back
  import sps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  output logic            head_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last_of_run,
  output logic            stream_end
);

  logic              out_valid;
  logic [RLEN_W-1:0] idx;
  logic              load;
  logic              is_last;
  logic [7:0]        pick;

  assign empty = !out_valid;
  assign load  = head_valid && (!out_valid || pop);

  // Byte for the current position of the head request.
  always_comb begin
    is_last  = (head.count == '0) || (idx == head.count - RLEN_W'(1));
    head_pop = load && is_last;
    if (head.count == '0) begin
      pick = 8'h00;
    end else if (head.is_replace) begin
      pick = cfg.replace_bytes[idx[RIDX_W-1:0]*8 +: 8];
    end else begin
      pick = head.seq_bytes[idx[WIDX_W-1:0]*8 +: 8];
    end
  end

  // Output register and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + RLEN_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= pick;
      byte_valid  <= (head.count != '0);
      last_of_run <= is_last;
      stream_end  <= is_last && head.eos;
    end
  end

endmodule
`default_nettype wire

// ===== src/stream_pattern_substitute_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         push / full          data_byte, end_of_stream
// result    out        empty / pop          out_byte, byte_valid, last_of_run, stream_end
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input byte is taken every cycle while the request queue (4 entries) has room.
// The output register holds one result at a time; a replacement of N bytes leaves it
// as N results. A first result passes through the request queue and then the output
// register before it shows on the result ports.
// Synchronous reset restores the register defaults and empties window and queue.
// Stalls at pop back up through the output register into the queue and then onto full.
module stream_pattern_substitute_unit
  import sps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last_of_run,
  output logic             stream_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]  match_pattern;
  logic [3:0]   match_length;
  logic [255:0] replace_words;
  logic [5:0]   replace_length;
  logic         once_mode;

  cfg_t cfg;
  cmd_t cmd;
  cmd_t head;
  logic cmd_push;
  logic head_valid;
  logic head_pop;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_pattern  <= '0;
      match_length   <= 4'd7;
      replace_words  <= '0;
      replace_length <= '0;
      once_mode      <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MATCH_PATTERN:  match_pattern          <= cfg_data;
        REG_MATCH_LENGTH:   match_length           <= cfg_data[3:0];
        REG_REPLACE_WORD0:  replace_words[63:0]    <= cfg_data;
        REG_REPLACE_WORD1:  replace_words[127:64]  <= cfg_data;
        REG_REPLACE_WORD2:  replace_words[191:128] <= cfg_data;
        REG_REPLACE_WORD3:  replace_words[255:192] <= cfg_data;
        REG_REPLACE_LENGTH: replace_length         <= cfg_data[5:0];
        REG_ONCE_MODE:      once_mode              <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the lengths into their working ranges.
  always_comb begin
    cfg.match_pattern = match_pattern;
    if (match_length == 4'd0) begin
      cfg.match_len = PLEN_W'(1);
    end else if (match_length > 4'(PATTERN_MAX)) begin
      cfg.match_len = PLEN_W'(PATTERN_MAX);
    end else begin
      cfg.match_len = PLEN_W'(match_length);
    end
    cfg.replace_bytes = replace_words[REPLACE_MAX*8-1:0];
    cfg.replace_len   = (replace_length > RLEN_W'(REPLACE_MAX)) ?
                        RLEN_W'(REPLACE_MAX) : replace_length;
    cfg.once_mode     = once_mode;
  end

  sps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  sps_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_cmd    (cmd),
    .full      (full),
    .rd_en     (head_pop),
    .head      (head),
    .not_empty (head_valid)
  );

  sps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_of_run (last_of_run),
    .stream_end  (stream_end)
  );

endmodule
`default_nettype wire

// ===== dv/tb_stream_pattern_substitute_unit.sv =====
`timescale 1ns / 1ps

module tb_stream_pattern_substitute_unit;
  import sps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  // One emitted byte as the result ports show it.
  typedef struct {
    logic [7:0] ch;
    logic       valid;
    logic       run_last;
    logic       strm_last;
  } emitted_t;

  // Predicts the substituted stream and holds the bytes still to come out.
  class subst_predictor;
    logic [63:0] pat_bits;
    logic [3:0]  pat_len_reg;
    logic [63:0] rep_words [4];
    logic [5:0]  rep_len_reg;
    logic        once_reg;
    logic [7:0]  win [PATTERN_MAX];
    int          held;
    bit          replaced;
    emitted_t    run [$];
    emitted_t    expected_bytes [$];
    int          errors;

    function new();
      pat_bits    = '0;
      pat_len_reg = 4'd7;
      rep_words   = '{default: '0};
      rep_len_reg = '0;
      once_reg    = 1'b1;
      replaced    = 0;
      errors      = 0;
      clear_window();
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] v);
      case (idx)
        REG_MATCH_PATTERN:  pat_bits     = v;
        REG_MATCH_LENGTH:   pat_len_reg  = v[3:0];
        REG_REPLACE_WORD0:  rep_words[0] = v;
        REG_REPLACE_WORD1:  rep_words[1] = v;
        REG_REPLACE_WORD2:  rep_words[2] = v;
        REG_REPLACE_WORD3:  rep_words[3] = v;
        REG_REPLACE_LENGTH: rep_len_reg  = v[5:0];
        REG_ONCE_MODE:      once_reg     = v[0];
        default: ;
      endcase
    endfunction

    // Pattern length with out-of-range settings clamped.
    function int active_len();
      int n;
      n = int'(pat_len_reg);
      if (n < 1) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      return n;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function void clear_window();
      foreach (win[i]) win[i] = '0;
      held = 0;
    endfunction

    function void emit(input logic [7:0] c, input logic v);
      emitted_t e;
      e.ch = c;
      e.valid = v;
      e.run_last = 1'b0;
      e.strm_last = 1'b0;
      run.push_back(e);
    endfunction

    // Emit the oldest held byte and slide the window down.
    function void shift_out();
      int i;
      if (held == 0) return;
      emit(win[0], 1'b1);
      for (i = 0; i < PATTERN_MAX - 1; i++) win[i] = win[i + 1];
      win[PATTERN_MAX - 1] = '0;
      held--;
    endfunction

    function void absorb_byte(input logic [7:0] b, input logic eos);
      int  n, rl, i, k;
      bit  hit;
      logic last;
      run.delete();
      n = active_len();
      if (once_reg && replaced) begin
        // Past the first replacement everything goes straight through.
        while (held > 0) shift_out();
        emit(b, 1'b1);
      end else if (held >= n) begin
        // Window already holds at least the pattern length, so just trim it.
        if (held < PATTERN_MAX) begin
          win[held] = b;
          held++;
        end
        while (held > n - 1) shift_out();
      end else begin
        win[held] = b;
        held++;
        if (held == n) begin
          hit = 1;
          for (i = 0; i < n; i++) begin
            if (fold(win[i]) != pat_bits[8*i +: 8]) hit = 0;
          end
          if (hit) begin
            rl = (int'(rep_len_reg) > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len_reg);
            for (k = 0; k < rl; k++) emit(rep_words[k >> 3][8*(k & 7) +: 8], 1'b1);
            clear_window();
            replaced = 1;
          end else begin
            shift_out();
          end
        end
      end
      // End of stream flushes the window and resets the stream state.
      if (eos) begin
        while (held > 0) shift_out();
        if (run.size() == 0) emit(8'h00, 1'b0);
        clear_window();
        replaced = 0;
      end
      foreach (run[j]) begin
        last = (j == run.size() - 1);
        run[j].run_last = last;
        run[j].strm_last = last && eos;
        expected_bytes.push_back(run[j]);
      end
    endfunction

    function void check_emitted(input logic [7:0] c, input logic v,
                                input logic rl, input logic se);
      emitted_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h byte_valid %0b", c, v);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (c !== e.ch) begin
        $error("out_byte: expected %02h, actual %02h", e.ch, c);
        errors++;
      end
      if (v !== e.valid) begin
        $error("byte_valid: expected %0b, actual %0b", e.valid, v);
        errors++;
      end
      if (rl !== e.run_last) begin
        $error("last_of_run: expected %0b, actual %0b", e.run_last, rl);
        errors++;
      end
      if (se !== e.strm_last) begin
        $error("stream_end: expected %0b, actual %0b", e.strm_last, se);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        end_of_stream = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_run;
  logic        stream_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  subst_predictor sb = new();

  stream_pattern_substitute_unit dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_of_run   (last_of_run),
    .stream_end    (stream_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, checked at the rising edge.
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_emitted(out_byte, byte_valid, last_of_run, stream_end);
    end
  end

  // Starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_stream <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.absorb_byte(b, e);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eos_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eos_last && (i == s.len() - 1));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [63:0] pat, input logic [3:0] plen,
                         input logic [63:0] w0, input logic [63:0] w1,
                         input logic [63:0] w2, input logic [63:0] w3,
                         input logic [5:0] rlen, input logic once);
    cfg_write(REG_MATCH_PATTERN, pat);
    cfg_write(REG_MATCH_LENGTH, 64'(plen));
    cfg_write(REG_REPLACE_WORD0, w0);
    cfg_write(REG_REPLACE_WORD1, w1);
    cfg_write(REG_REPLACE_WORD2, w2);
    cfg_write(REG_REPLACE_WORD3, w3);
    cfg_write(REG_REPLACE_LENGTH, 64'(rlen));
    cfg_write(REG_ONCE_MODE, 64'(once));
  endtask

  // Wait for every expected byte, then let any held-only work settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] r;
    int i;
    r = '0;
    for (i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [63:0] rand_qword();
    return {$urandom, $urandom};
  endfunction

  // Lowercase letters from a small alphabet so partial overlaps are common.
  function automatic logic [63:0] rand_letters();
    logic [63:0] r;
    int i;
    for (i = 0; i < 8; i++) r[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
    return r;
  endfunction

  // Mostly pattern occurrences with random case, some cut short, plus noise.
  task automatic send_traffic(input int count);
    int sent, mode, cut, i;
    logic [7:0] b;
    logic e;
    sent = 0;
    while (sent < count) begin
      mode = int'($urandom_range(0, 9));
      if (mode < 6) begin
        cut = (mode < 4) ? sb.active_len() : int'($urandom_range(0, sb.active_len() - 1));
        for (i = 0; i < cut && sent < count; i++) begin
          b = sb.pat_bits[8*i +: 8];
          if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1) == 1) b = b - 8'd32;
          e = ($urandom_range(0, 19) == 0);
          send_byte(b, e);
          sent++;
        end
      end else begin
        b = (mode == 9) ? sb.pat_bits[8*$urandom_range(0, 7) +: 8] : 8'($urandom_range(0, 255));
        e = ($urandom_range(0, 7) == 0);
        send_byte(b, e);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct = idle;
    stall_pct = stall;
    send_traffic(count);
    wait_drained();
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: seven zero bytes match the zero pattern and are deleted,
    // so the stream end comes out as an empty marker.
    for (i = 0; i < 7; i++) send_byte(8'h00, i == 6);
    send_byte(8'hff, 1'b1);
    wait_drained();

    // Mixed-case match with a replacement, repeated matches allowed.
    set_all(pack_text("</head>"), 4'd7, pack_text("\n</head>"), '1, '0, '0, 6'd8, 1'b0);
    send_text("x</HEAD>", 0);
    send_text("</h", 0);
    wait_drained();

    // Switching to once mode with bytes still held flushes them first.
    cfg_write(REG_ONCE_MODE, 64'd1);
    send_byte("Z", 1'b1);
    send_text("abcdef", 0);
    wait_drained();

    // Pattern length lowered below the held count mid-stream.
    cfg_write(REG_MATCH_LENGTH, 64'd0);
    send_byte("g", 1'b1);
    wait_drained();

    // Random traffic under several settings and flow-control mixes.
    set_all(pack_text("</head>"), 4'd7, pack_text("\n</head>"), '0, '0, '0, 6'd8, 1'b1);
    run_phase(0, 0, 60);
    set_all(rand_letters(), 4'd15, rand_qword(), rand_qword(), rand_qword(), rand_qword(),
            6'd63, 1'b0);
    run_phase(74, 0, 60);
    set_all(64'hff, 4'd1, '1, '0, rand_qword(), rand_qword(), 6'd32, 1'b0);
    run_phase(0, 74, 60);
    // An uppercase pattern byte can never match.
    set_all(pack_text("xAy"), 4'd3, rand_qword(), '0, '0, '0, 6'd0, 1'b1);
    run_phase(32, 32, 60);
    set_all(rand_letters(), 4'd8, rand_qword(), '0, '0, '0, 6'd1, 1'b0);
    run_phase(32, 32, 60);
    set_all(rand_letters(), 4'd2, rand_qword(), '0, '0, '0, 6'd0, 1'b0);
    run_phase(0, 0, 60);

    if (sb.pending() != 0) begin
      $error("%0d expected bytes never came out", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
